@@ rtl/kscs_pkg.sv @@
// Shared types and constants for the keyframe scalar curve sampler.
package kscs_pkg;

    // Fraction bits of the interpolation parameter t (unsigned Q1.28)
    localparam int T_BITS = 28;
    localparam int KEY_DEPTH_DEF = 256;

    // Field widths
    localparam int FRAME_W = 24;
    localparam int VALUE_W = 32;
    localparam int MODE_W = 2;
    localparam int HEAD_W = 32;
    localparam int COUNT_W = 9;

    // Interpolation modes; the unused code falls back to linear
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;

    // One keyframe as held in the table
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] tan_in;
        logic [VALUE_W-1:0] tan_out;
    } key_entry_t;

    // Beat handed from one divider cell to the next
    typedef struct packed {
        logic              valid;
        logic [HEAD_W-1:0] rem;
        logic [HEAD_W-1:0] den;
        logic [T_BITS-1:0] quo;
    } div_beat_t;

endpackage

@@ rtl/kscs_store.sv @@
// Keyframe table: one write port, one registered read port.
module kscs_store
    import kscs_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF,
    localparam int AW = $clog2(KEY_DEPTH)
)
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_entry_t wr_data,
    input  logic [AW-1:0] rd_addr,
    output key_entry_t rd_data
);

    key_entry_t mem [KEY_DEPTH];
    key_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/kscs_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per beat.
module kscs_div_cell
    import kscs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_beat_t din,
    output div_beat_t dout
);

    logic              valid_reg;
    div_beat_t         beat_reg;
    logic [HEAD_W:0]   rem2;
    logic              ge;
    div_beat_t         beat_next;

    // shift remainder, trial subtract
    always_comb
    begin
        rem2 = {din.rem, 1'b0};
        ge = (rem2 >= {1'b0, din.den});
        beat_next = din;
        beat_next.rem = ge ? HEAD_W'(rem2 - {1'b0, din.den}) : rem2[HEAD_W-1:0];
        beat_next.quo = {din.quo[T_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_comb
    begin
        dout = beat_reg;
        dout.valid = valid_reg;
    end

endmodule

@@ rtl/kscs_div_chain.sv @@
// Row of division cells computing floor(num * 2^T_BITS / den) for num < den.
module kscs_div_chain
    import kscs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_beat_t din,
    output div_beat_t dout
);

    div_beat_t beats [T_BITS+1];

    assign beats[0] = din;

    for (genvar g = 0; g < T_BITS; g++)
    begin : g_cell
        kscs_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (beats[g]),
            .dout (beats[g+1])
        );
    end

    assign dout = beats[T_BITS];

endmodule

@@ rtl/keyframe_scalar_curve_sampler.sv @@
// Top level of the keyframe scalar curve sampler.
// A write beat (tuser 0) stores one keyframe. A sample beat (tuser 1) is worked
// on alone: the table is read through one memory port, and a sample passes
// through the key scan (one key per cycle), the 28-cell divider row and a
// shared 33x33 multiplier (t squared and t cubed, then four products for
// hermite; two products for linear). An empty table, a head outside the keys
// and a step or flat segment skip the divider and the multiplier.
// A finished result waits in the output register while the next beat enters.
module keyframe_scalar_curve_sampler
    import kscs_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_slot, key_frame, key_value, key_mode, tangent_incoming,
    // tangent_outgoing, play_head, zero pad
    input  logic [167:0] s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sample_value
    output logic [31:0]  m_axis_tdata,
    // table_empty, saturated
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(KEY_DEPTH);
    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int TW = T_BITS + 1;
    localparam int OPW = VALUE_W + 1;
    localparam int PW = 2 * OPW;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_F0, S_FL, S_SCAN, S_K, S_K1, S_DIV,
        S_T2, S_T3, S_W, S_MAC, S_FIN, S_OUT
    } state_t;

    // input fields
    logic [7:0]         in_slot;
    key_entry_t         in_key;
    logic [HEAD_W-1:0]  in_head;

    assign in_slot = s_axis_tdata[7:0];
    assign in_key.frame = s_axis_tdata[31:8];
    assign in_key.value = s_axis_tdata[63:32];
    assign in_key.mode = s_axis_tdata[65:64];
    assign in_key.tan_in = s_axis_tdata[97:66];
    assign in_key.tan_out = s_axis_tdata[129:98];
    assign in_head = s_axis_tdata[161:130];

    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [FRAME_W-1:0] prev_reg, prev_next;
    logic [VALUE_W-1:0] v0_reg, v0_next, v1_reg, v1_next;
    logic [VALUE_W-1:0] tout_reg, tout_next, tin_reg, tin_next;
    logic               herm_reg, herm_next, tfull_reg, tfull_next;
    logic [TW-1:0]      t_reg, t_next, t2_reg, t2_next, t3_reg, t3_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_empty_reg, res_empty_next, res_sat_reg, res_sat_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_empty_reg, out_empty_next, out_sat_reg, out_sat_next;
    logic [COUNT_W-1:0] key_count_reg, key_count_next;
    logic [FRAME_W-1:0] fa_reg, fa_next;

    logic               wr_en;
    key_entry_t         rd_data;
    div_beat_t          div_in, div_out;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  prod_reg;
    logic signed [OPW-1:0] w_sel, op_sel;
    logic signed [OPW-1:0] h00, h10, h01, h11;
    logic [2:0]         nprod;
    logic [HEAD_W-1:0]  fa_full, fb_full, den, num;
    logic signed [PW-T_BITS-1:0] shifted;
    logic               in_beat, sample_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign sample_beat = in_beat && s_axis_tuser;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // keyframe writes, slots beyond the table dropped
    assign wr_en = in_beat && !s_axis_tuser && ({24'd0, in_slot} < 32'(KEY_DEPTH));

    kscs_store #(.KEY_DEPTH(KEY_DEPTH)) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(AW'(in_slot)),
        .wr_data(in_key),
        .rd_addr(addr_next),
        .rd_data(rd_data)
    );

    kscs_div_chain u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (div_in),
        .dout (div_out)
    );

    // Hermite basis weights, signed Q4.28
    always_comb
    begin
        h00 = 2 * $signed({4'b0, t3_reg}) - 3 * $signed({4'b0, t2_reg})
            + $signed({4'b0, T_ONE});
        h10 = $signed({4'b0, t3_reg}) - 2 * $signed({4'b0, t2_reg})
            + $signed({4'b0, t_reg});
        h01 = 3 * $signed({4'b0, t2_reg}) - 2 * $signed({4'b0, t3_reg});
        h11 = $signed({4'b0, t3_reg}) - $signed({4'b0, t2_reg});
    end

    // weight and operand for the current product
    always_comb
    begin
        w_sel = '0;
        op_sel = '0;
        if (herm_reg)
        begin
            case (cnt_reg)
                3'd0:
                begin
                    w_sel = h00;
                    op_sel = $signed({v0_reg[31], v0_reg});
                end
                3'd1:
                begin
                    w_sel = h10;
                    op_sel = $signed({tout_reg[31], tout_reg});
                end
                3'd2:
                begin
                    w_sel = h01;
                    op_sel = $signed({v1_reg[31], v1_reg});
                end
                default:
                begin
                    w_sel = h11;
                    op_sel = $signed({tin_reg[31], tin_reg});
                end
            endcase
        end
        else
        begin
            case (cnt_reg)
                3'd0:
                begin
                    w_sel = $signed({4'b0, T_ONE - t_reg});
                    op_sel = $signed({v0_reg[31], v0_reg});
                end
                default:
                begin
                    w_sel = $signed({4'b0, t_reg});
                    op_sel = $signed({v1_reg[31], v1_reg});
                end
            endcase
        end
    end

    assign nprod = herm_reg ? 3'd4 : 3'd2;
    assign fa_full = {fa_reg, 8'd0};
    assign fb_full = {rd_data.frame, 8'd0};
    assign den = fb_full - fa_full;
    assign num = (head_reg >= fa_full) ? head_reg - fa_full : '0;
    assign shifted = acc_reg[PW-1:T_BITS];

    // shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        head_next = head_reg;
        n_next = n_reg;
        prev_next = prev_reg;
        fa_next = fa_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        tout_next = tout_reg;
        tin_next = tin_reg;
        herm_next = herm_reg;
        tfull_next = tfull_reg;
        t_next = t_reg;
        t2_next = t2_reg;
        t3_next = t3_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        res_value_next = res_value_reg;
        res_empty_next = res_empty_reg;
        res_sat_next = res_sat_reg;
        key_count_next = key_count_reg;
        mul_a = '0;
        mul_b = '0;
        div_in = '0;

        if (cfg_valid && cfg_ready)
        begin
            key_count_next = cfg_data;
        end

        // output register drains independently
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;
        out_sat_next = out_sat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_beat)
                begin
                    head_next = in_head;
                    if ({23'd0, key_count_reg} > 32'(KEY_DEPTH))
                    begin
                        n_next = CW'(KEY_DEPTH);
                    end
                    else
                    begin
                        n_next = CW'(key_count_reg);
                    end
                    res_empty_next = 1'b0;
                    res_sat_next = 1'b0;
                    if (key_count_reg == '0)
                    begin
                        res_value_next = '0;
                        res_empty_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        addr_next = '0;
                        state_next = S_F0;
                    end
                end
            end
            S_F0:
            begin
                if (head_reg <= {rd_data.frame, 8'd0})
                begin
                    res_value_next = rd_data.value;
                    state_next = S_OUT;
                end
                else
                begin
                    prev_next = rd_data.frame;
                    addr_next = AW'(n_reg - 1'b1);
                    state_next = S_FL;
                end
            end
            S_FL:
            begin
                if (head_reg >= {rd_data.frame, 8'd0})
                begin
                    res_value_next = rd_data.value;
                    state_next = S_OUT;
                end
                else
                begin
                    addr_next = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // first segment holding the head
                if (head_reg >= {prev_reg, 8'd0} && head_reg < {rd_data.frame, 8'd0})
                begin
                    addr_next = addr_reg - 1'b1;
                    state_next = S_K;
                end
                else if (addr_reg == AW'(n_reg - 1'b1))
                begin
                    addr_next = AW'(n_reg - 2'd2);
                    state_next = S_K;
                end
                else
                begin
                    prev_next = rd_data.frame;
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_K:
            begin
                fa_next = rd_data.frame;
                v0_next = rd_data.value;
                tout_next = rd_data.tan_out;
                herm_next = (rd_data.mode == MODE_HERMITE);
                tfull_next = (rd_data.mode == MODE_STEP);
                addr_next = addr_reg + 1'b1;
                state_next = S_K1;
            end
            S_K1:
            begin
                v1_next = rd_data.value;
                tin_next = rd_data.tan_in;
                herm_next = herm_reg || (rd_data.mode == MODE_HERMITE);
                if (rd_data.frame <= fa_reg || tfull_reg || rd_data.mode == MODE_STEP)
                begin
                    // flat segment or step key
                    res_value_next = v0_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    tfull_next = (num >= den);
                    div_in.valid = 1'b1;
                    div_in.rem = num;
                    div_in.den = den;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_out.valid)
                begin
                    t_next = tfull_reg ? T_ONE : {1'b0, div_out.quo};
                    cnt_next = '0;
                    acc_next = '0;
                    state_next = herm_reg ? S_T2 : S_MAC;
                end
            end
            S_T2:
            begin
                mul_a = $signed({4'b0, t_reg});
                mul_b = $signed({4'b0, t_reg});
                state_next = S_T3;
            end
            S_T3:
            begin
                t2_next = prod_reg[T_BITS+TW-1:T_BITS];
                mul_a = $signed({4'b0, prod_reg[T_BITS+TW-1:T_BITS]});
                mul_b = $signed({4'b0, t_reg});
                state_next = S_W;
            end
            S_W:
            begin
                t3_next = prod_reg[T_BITS+TW-1:T_BITS];
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (cnt_reg < nprod)
                begin
                    mul_a = w_sel;
                    mul_b = op_sel;
                end
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + prod_reg;
                end
                if (cnt_reg == nprod)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                // floor shift, then clip to 32 bits
                if (shifted > $signed((PW-T_BITS)'(32'h7FFF_FFFF)))
                begin
                    res_value_next = 32'h7FFF_FFFF;
                    res_sat_next = 1'b1;
                end
                else if (shifted < -$signed((PW-T_BITS)'(33'h0_8000_0000)))
                begin
                    res_value_next = 32'h8000_0000;
                    res_sat_next = 1'b1;
                end
                else
                begin
                    res_value_next = shifted[VALUE_W-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_empty_next = res_empty_reg;
                    out_sat_next = res_sat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            key_count_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            key_count_reg <= key_count_next;
            addr_reg <= addr_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        n_reg <= n_next;
        prev_reg <= prev_next;
        fa_reg <= fa_next;
        v0_reg <= v0_next;
        v1_reg <= v1_next;
        tout_reg <= tout_next;
        tin_reg <= tin_next;
        herm_reg <= herm_next;
        tfull_reg <= tfull_next;
        t_reg <= t_next;
        t2_reg <= t2_next;
        t3_reg <= t3_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        res_value_reg <= res_value_next;
        res_empty_reg <= res_empty_next;
        res_sat_reg <= res_sat_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
        out_sat_reg <= out_sat_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_value_reg;
    assign m_axis_tuser = {out_sat_reg, out_empty_reg};

endmodule

@@ rtl/kscs_checker.sv @@
// Port-level checks for the curve sampler, bound to the top level.
module kscs_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // empty table gives zero, never clipped
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0 && !m_axis_tuser[1])
        else $error("empty result carries data");

    // a clipped result sits at a rail
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
        m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
        else $error("saturated result off the rails");

    // the input is not ready in the cycle after a sample beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input taken right after a sample beat");

endmodule

bind keyframe_scalar_curve_sampler kscs_checker u_kscs_checker (.*);

@@ sim/tb_keyframe_scalar_curve_sampler.sv @@
// Self-checking testbench for the keyframe scalar curve sampler.
module tb_keyframe_scalar_curve_sampler;
    import kscs_pkg::*;

    localparam int DEPTH = 256;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic        act;
        logic [7:0]  slot;
        logic [23:0] frame;
        logic [31:0] value;
        logic [1:0]  mode;
        logic [31:0] tin;
        logic [31:0] tout;
        logic [31:0] head;
    } key_beat_t;

    typedef struct {
        logic [31:0] value;
        logic        empty;
        logic        sat;
    } curve_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    key_beat_t     pending_beats[$];
    curve_result_t expected_samples[$];

    // Predictor state: table copy and key count
    logic [23:0] tbl_frame[DEPTH];
    logic [31:0] tbl_value[DEPTH];
    logic [1:0]  tbl_mode[DEPTH];
    logic [31:0] tbl_tin[DEPTH];
    logic [31:0] tbl_tout[DEPTH];
    int          tbl_count;

    // Stimulus-side copy of the frames, used to aim play heads
    logic [23:0] gen_frame[DEPTH];
    int          gen_count;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int cycles;
    int queued_items;

    keyframe_scalar_curve_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [167:0] pack_beat(key_beat_t b);
        return {6'd0, b.head, b.tout, b.tin, b.mode, b.value, b.frame, b.slot};
    endfunction

    // Apply one accepted beat to the table copy and queue the expected sample
    function automatic void curve_predict(key_beat_t b);
        int n, k, i;
        bit found;
        logic [63:0] hd, a, c, num, den;
        longint t, t2, t3, h00, h10, h01, h11, acc;
        curve_result_t r;
        if (!b.act)
        begin
            tbl_frame[b.slot] = b.frame;
            tbl_value[b.slot] = b.value;
            tbl_mode[b.slot] = b.mode;
            tbl_tin[b.slot] = b.tin;
            tbl_tout[b.slot] = b.tout;
            return;
        end
        r.empty = 1'b0;
        r.sat = 1'b0;
        hd = {32'd0, b.head};
        n = (tbl_count > DEPTH) ? DEPTH : tbl_count;
        if (n == 0)
        begin
            r.value = '0;
            r.empty = 1'b1;
        end
        else if (hd <= {32'd0, tbl_frame[0], 8'd0})
            r.value = tbl_value[0];
        else if (hd >= {32'd0, tbl_frame[n-1], 8'd0})
            r.value = tbl_value[n-1];
        else
        begin
            k = n - 2;
            found = 0;
            for (i = 0; i + 1 < n; i++)
            begin
                a = {32'd0, tbl_frame[i], 8'd0};
                c = {32'd0, tbl_frame[i+1], 8'd0};
                if (!found && hd >= a && hd < c)
                begin
                    k = i;
                    found = 1;
                end
            end
            a = {32'd0, tbl_frame[k], 8'd0};
            c = {32'd0, tbl_frame[k+1], 8'd0};
            if (c <= a || tbl_mode[k] == MODE_STEP || tbl_mode[k+1] == MODE_STEP)
                r.value = tbl_value[k];
            else
            begin
                den = c - a;
                num = (hd >= a) ? hd - a : 64'd0;
                if (num > den)
                    num = den;
                t = longint'((num << T_BITS) / den);
                if (tbl_mode[k] == MODE_HERMITE || tbl_mode[k+1] == MODE_HERMITE)
                begin
                    t2 = (t * t) >>> T_BITS;
                    t3 = (t2 * t) >>> T_BITS;
                    h00 = 2 * t3 - 3 * t2 + (64'sd1 <<< T_BITS);
                    h10 = t3 - 2 * t2 + t;
                    h01 = -2 * t3 + 3 * t2;
                    h11 = t3 - t2;
                    acc = h00 * longint'(signed'(tbl_value[k]))
                        + h10 * longint'(signed'(tbl_tout[k]))
                        + h01 * longint'(signed'(tbl_value[k+1]))
                        + h11 * longint'(signed'(tbl_tin[k+1]));
                end
                else
                    acc = ((64'sd1 <<< T_BITS) - t) * longint'(signed'(tbl_value[k]))
                        + t * longint'(signed'(tbl_value[k+1]));
                acc = acc >>> T_BITS;
                if (acc > 64'sd2147483647)
                begin
                    r.value = 32'h7FFF_FFFF;
                    r.sat = 1'b1;
                end
                else if (acc < -64'sd2147483648)
                begin
                    r.value = 32'h8000_0000;
                    r.sat = 1'b1;
                end
                else
                    r.value = acc[31:0];
            end
        end
        expected_samples = {expected_samples, r};
    endfunction

    // Driver: feeds pending beats, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                curve_predict(pending_beats.pop_front());
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pack_beat(pending_beats[0]);
                s_axis_tuser <= pending_beats[0].act;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        curve_result_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: value %h user %b",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    e = expected_samples.pop_front();
                    if (m_axis_tdata !== e.value || m_axis_tuser[0] !== e.empty ||
                        m_axis_tuser[1] !== e.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value %h empty %b sat %b, got %h %b %b",
                                     e.value, e.empty, e.sat, m_axis_tdata,
                                     m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(2097152)) - 1048576);
            3: return 32'(int'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_write(int slot, logic [23:0] frame, logic [1:0] mode);
        key_beat_t b;
        b.act = 1'b0;
        b.slot = slot[7:0];
        b.frame = frame;
        b.value = rand_word();
        b.mode = mode;
        b.tin = rand_word();
        b.tout = rand_word();
        b.head = $urandom;
        pending_beats = {pending_beats, b};
        gen_frame[slot] = frame;
        queued_items++;
    endfunction

    function automatic void queue_sample(logic [31:0] head);
        key_beat_t b;
        b.act = 1'b1;
        b.slot = 8'($urandom);
        b.frame = 24'($urandom);
        b.value = $urandom;
        b.mode = 2'($urandom);
        b.tin = $urandom;
        b.tout = $urandom;
        b.head = head;
        pending_beats = {pending_beats, b};
        queued_items++;
    endfunction

    // Ascending keys in slots 0..n-1 with occasional repeated frames
    function automatic void queue_table(int n);
        longint f;
        int i;
        f = (n > 64) ? $urandom_range(4000) : $urandom_range(24'hFFFFFF);
        for (i = 0; i < n; i++)
        begin
            if (f > 24'hFFFFFF)
                f = 24'hFFFFFF;
            queue_write(i, f[23:0], 2'($urandom_range(3)));
            case ($urandom_range(11))
                0: f = f;
                1: f = f + $urandom_range(65535);
                default: f = f + $urandom_range(300, 1);
            endcase
        end
    endfunction

    function automatic logic [31:0] pick_head();
        int n, j;
        longint lo, hi;
        n = (gen_count > DEPTH) ? DEPTH : gen_count;
        if (n == 0)
            return $urandom;
        j = $urandom_range(n - 1);
        lo = {gen_frame[0], 8'd0};
        hi = {gen_frame[n-1], 8'd0};
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return {gen_frame[j], 8'd0};
            3: return {gen_frame[j], 8'd0} + $urandom_range(255);
            4: return $urandom;
            5: return 32'(lo - $urandom_range(3));
            6: return 32'(hi + $urandom_range(3));
            default:
                if (hi > lo)
                    return 32'(lo + longint'($urandom) % (hi - lo + 1));
                else
                    return 32'(lo);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_count(int v);
        cfg_valid <= 1'b1;
        cfg_data <= v[COUNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tbl_count = v;
        gen_count = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int counts[6];
        int p, n, i, s;
        counts = '{0, 1, 2, 3, 256, 511};
        mismatches = 0;
        cycles = 0;
        queued_items = 0;
        tbl_count = 0;
        gen_count = 0;
        send_idle_pct = 23;
        recv_idle_pct = 47;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table right after reset
        queue_sample(32'd0);
        queue_sample(32'hFFFF_FFFF);
        queue_sample($urandom);
        // Fill the whole table so any count reads only written keys
        queue_table(DEPTH);
        wait_idle();

        p = 0;
        while (queued_items < 1100)
        begin
            if (queued_items > 750)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (queued_items > 400)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 23;
            end
            if (p < 6)
                n = counts[p];
            else if ($urandom_range(9) == 0)
                n = $urandom_range(511);
            else
                n = $urandom_range(16, 2);
            write_key_count(n);
            if (n > 0 && n <= 32)
                queue_table(n);
            s = (n > 64) ? 12 : 24;
            for (i = 0; i < s; i++)
            begin
                // Stray rewrite of a key now and then
                if ($urandom_range(15) == 0)
                    queue_write(int'($urandom_range(DEPTH - 1)), 24'($urandom),
                                2'($urandom_range(3)));
                queue_sample(pick_head());
            end
            wait_idle();
            p++;
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
